// ----- design/pdsch_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsch_pkg
// Shared types and constants for the periodic dispatch scheduler: table size,
// command and cell operation codes, and the sorted-entry format.
// ----------------------------------------------------------------------------
package pdsch_pkg;

	localparam int CAPACITY = 64;
	localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 2;
	localparam int ID_W     = 31;
	localparam int PER_W    = 16;
	localparam int TIME_W   = 40;
	localparam int STAT_W   = 2;

	localparam logic [CMD_W-1:0] CMD_REG  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DISP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLR  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_HOLD = 2'd0;
	localparam logic [OP_W-1:0] OP_INS  = 2'd1;
	localparam logic [OP_W-1:0] OP_REP  = 2'd2;

	// ordering key: due time, then identifier, then registration slot
	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
		logic [POS_W-1:0]  pos;
	} key_t;

	typedef struct packed {
		key_t             key;
		logic [PER_W-1:0] per;
	} entry_t;

	typedef struct packed {
		entry_t e;
		logic   lt;
	} nbr_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		entry_t          k;
	} ctl_t;

endpackage

// ----- design/pdsch_cell.sv -----
// ----------------------------------------------------------------------------
// pdsch_cell
// One slot of the sorted chain. Holds one entry, compares it with the
// broadcast entry and takes its own, its neighbor's or the broadcast entry.
// ----------------------------------------------------------------------------
module pdsch_cell (
	input  logic              clk,
	input  logic              first,
	input  logic              vld,
	input  pdsch_pkg::ctl_t   ctl,
	input  pdsch_pkg::nbr_t   prev,
	input  pdsch_pkg::nbr_t   next,
	output pdsch_pkg::nbr_t   own
);

	pdsch_pkg::entry_t e_q;
	pdsch_pkg::entry_t e_nxt;
	logic              own_lt;

	assign own_lt = vld && (e_q.key < ctl.k.key);
	assign own.e  = e_q;
	assign own.lt = own_lt;

	always_comb begin
		e_nxt = e_q;
		case (ctl.op)
			pdsch_pkg::OP_INS: begin
				if (own_lt)
					e_nxt = e_q;
				else if (first || prev.lt)
					e_nxt = ctl.k;
				else
					e_nxt = prev.e;
			end
			pdsch_pkg::OP_REP: begin
				if (next.lt)
					e_nxt = next.e;
				else if (first || own_lt)
					e_nxt = ctl.k;
				else
					e_nxt = e_q;
			end
			default: e_nxt = e_q;
		endcase
	end

	always_ff @(posedge clk) begin
		e_q <= e_nxt;
	end

endmodule

// ----- design/periodic_dispatch_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_dispatch_scheduler_core
// Periodic source scheduler built on a sorted chain of cells, earliest due
// entry at the head. Dispatch reports the head and re-inserts it re-armed.
//
//   channel | handshake          | fields
//   --------+--------------------+---------------------------------
//   command | start / busy       | cmd, user_id, period
//   result  | done (one cycle)   | sent_id, sent_time, status
//
// register and dispatch are accepted, then run a chain update state (S_INS or S_REP);
// clear, empty dispatch, full register and unused codes finish at accept with no update
// the result appears in the cycle after accept; the chain update runs with it
// busy is high only during the chain update cycle
// reset empties the table; no clearing pass is needed
// ----------------------------------------------------------------------------
module periodic_dispatch_scheduler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pdsch_pkg::CMD_W-1:0]     cmd,
	input  logic [pdsch_pkg::ID_W-1:0]      user_id,
	input  logic [pdsch_pkg::PER_W-1:0]     period,
	output logic                            done,
	output logic [pdsch_pkg::ID_W-1:0]      sent_id,
	output logic [pdsch_pkg::TIME_W-1:0]    sent_time,
	output logic [pdsch_pkg::STAT_W-1:0]    status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_REP  = 2'd2;

	logic [1:0]                        state_q;
	logic [pdsch_pkg::CNT_W-1:0]       count_q;
	pdsch_pkg::entry_t                 k_q;
	logic                              done_q;
	logic [pdsch_pkg::ID_W-1:0]        sent_id_q;
	logic [pdsch_pkg::TIME_W-1:0]      sent_time_q;
	logic [pdsch_pkg::STAT_W-1:0]      status_q;

	logic                              accept;
	logic                              full;
	logic                              empty;
	logic [pdsch_pkg::TIME_W:0]        sum;
	logic [pdsch_pkg::TIME_W-1:0]      arm_due;
	pdsch_pkg::ctl_t                   ctl;
	pdsch_pkg::nbr_t                   link [pdsch_pkg::CAPACITY];
	logic [pdsch_pkg::CAPACITY-1:0]    vld;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == pdsch_pkg::CNT_W'(pdsch_pkg::CAPACITY));
	assign empty  = (count_q == '0);

	// saturating re-arm of the head entry
	assign sum     = {1'b0, link[0].e.key.due} + {{(pdsch_pkg::TIME_W + 1 - pdsch_pkg::PER_W){1'b0}},
			link[0].e.per};
	assign arm_due = sum[pdsch_pkg::TIME_W] ? {pdsch_pkg::TIME_W{1'b1}}
			: sum[pdsch_pkg::TIME_W-1:0];

	always_comb begin
		ctl.k = k_q;
		unique case (state_q)
			S_INS:   ctl.op = pdsch_pkg::OP_INS;
			S_REP:   ctl.op = pdsch_pkg::OP_REP;
			default: ctl.op = pdsch_pkg::OP_HOLD;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < pdsch_pkg::CAPACITY; gi++) begin : g_cell
			pdsch_pkg::nbr_t prev_n;
			pdsch_pkg::nbr_t next_n;

			assign vld[gi] = (count_q > pdsch_pkg::CNT_W'(gi));

			if (gi == 0) begin : g_head
				assign prev_n = '{e: link[0].e, lt: 1'b0};
			end else begin : g_body
				assign prev_n = link[gi-1];
			end

			if (gi == pdsch_pkg::CAPACITY - 1) begin : g_tail
				assign next_n = '{e: link[gi].e, lt: 1'b0};
			end else begin : g_mid
				assign next_n = link[gi+1];
			end

			pdsch_cell u_cell (
				.clk   (clk),
				.first (gi == 0),
				.vld   (vld[gi]),
				.ctl   (ctl),
				.prev  (prev_n),
				.next  (next_n),
				.own   (link[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							pdsch_pkg::CMD_REG:  if (!full) state_q <= S_INS;
							pdsch_pkg::CMD_DISP: if (!empty) state_q <= S_REP;
							pdsch_pkg::CMD_CLR:  count_q <= '0;
							default: ;
						endcase
					end
				end
				S_INS: begin
					count_q <= count_q + pdsch_pkg::CNT_W'(1);
					state_q <= S_IDLE;
				end
				S_REP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sent_id_q   <= '0;
			sent_time_q <= '0;
			status_q    <= pdsch_pkg::ST_OK;
			case (cmd)
				pdsch_pkg::CMD_REG: begin
					if (full)
						status_q <= pdsch_pkg::ST_FULL;
					k_q.key.due <= {{(pdsch_pkg::TIME_W - pdsch_pkg::PER_W){1'b0}}, period};
					k_q.key.id  <= user_id;
					k_q.key.pos <= count_q[pdsch_pkg::POS_W-1:0];
					k_q.per     <= period;
				end
				pdsch_pkg::CMD_DISP: begin
					if (empty) begin
						status_q <= pdsch_pkg::ST_EMPTY;
					end else begin
						sent_id_q   <= link[0].e.key.id;
						sent_time_q <= link[0].e.key.due;
					end
					k_q.key.due <= arm_due;
					k_q.key.id  <= link[0].e.key.id;
					k_q.key.pos <= link[0].e.key.pos;
					k_q.per     <= link[0].e.per;
				end
				default: ;
			endcase
		end
	end

	assign done      = done_q;
	assign sent_id   = sent_id_q;
	assign sent_time = sent_time_q;
	assign status    = status_q;

endmodule

// ----- bench/tb_periodic_dispatch_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_dispatch_scheduler_core
// Self-checking bench for the periodic dispatch scheduler. A clocked driver
// feeds commands from a queue filled phase by phase: a short directed run,
// then random cases of clear, register bursts (up to and past a full table)
// and dispatch runs, often with tight registered id and period ranges to force
// ties, plus noise. The monitor keeps its own copy of the source table, predicts
// every result and compares it field by field with what the block reports.
// ----------------------------------------------------------------------------
module tb_periodic_dispatch_scheduler_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pdsch_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 225;

	typedef struct packed {
		logic [pdsch_pkg::CMD_W-1:0] cmd;
		logic [pdsch_pkg::ID_W-1:0]  uid;
		logic [pdsch_pkg::PER_W-1:0] per;
	} command_t;

	typedef struct packed {
		logic [pdsch_pkg::ID_W-1:0]   id;
		logic [pdsch_pkg::TIME_W-1:0] due;
		logic [pdsch_pkg::STAT_W-1:0] st;
	} grant_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [pdsch_pkg::CMD_W-1:0]   cmd = pdsch_pkg::CMD_CLR;
	logic [pdsch_pkg::ID_W-1:0]    user_id = '0;
	logic [pdsch_pkg::PER_W-1:0]   period = '0;
	logic                          done;
	logic [pdsch_pkg::ID_W-1:0]    sent_id;
	logic [pdsch_pkg::TIME_W-1:0]  sent_time;
	logic [pdsch_pkg::STAT_W-1:0]  status;

	command_t pending_cmds[$];
	grant_t   expected_grants[$];
	command_t next_cmd;
	bit       took = 1'b0;
	int       idle_pct = 0;
	int       quiet_cycles = 0;
	int       errors = 0;

	logic [pdsch_pkg::TIME_W-1:0] tbl_due[pdsch_pkg::CAPACITY];
	logic [pdsch_pkg::ID_W-1:0]   tbl_id[pdsch_pkg::CAPACITY];
	logic [pdsch_pkg::PER_W-1:0]  tbl_per[pdsch_pkg::CAPACITY];
	int                           tbl_count = 0;

	periodic_dispatch_scheduler_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.user_id(user_id),
		.period(period),
		.done(done),
		.sent_id(sent_id),
		.sent_time(sent_time),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic grant_t serve_command(command_t c);
		grant_t g;
		int best;
		logic [pdsch_pkg::TIME_W:0] sum;
		g = '0;
		case (c.cmd)
			pdsch_pkg::CMD_REG: begin
				if (tbl_count >= pdsch_pkg::CAPACITY) begin
					g.st = pdsch_pkg::ST_FULL;
				end else begin
					tbl_due[tbl_count] = pdsch_pkg::TIME_W'(c.per);
					tbl_id[tbl_count] = c.uid;
					tbl_per[tbl_count] = c.per;
					tbl_count++;
				end
			end
			pdsch_pkg::CMD_DISP: begin
				if (tbl_count == 0) begin
					g.st = pdsch_pkg::ST_EMPTY;
				end else begin
					best = 0;
					for (int i = 1; i < tbl_count; i++)
						if (tbl_due[i] < tbl_due[best] ||
						    (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
							best = i;
					g.id = tbl_id[best];
					g.due = tbl_due[best];
					sum = {1'b0, tbl_due[best]} + tbl_per[best];
					tbl_due[best] = sum[pdsch_pkg::TIME_W] ? '1
						: sum[pdsch_pkg::TIME_W-1:0];
				end
			end
			pdsch_pkg::CMD_CLR: begin
				tbl_count = 0;
			end
			default: begin
			end
		endcase
		return g;
	endfunction

	// driver: hold an offered transaction until it is taken
	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				cmd <= next_cmd.cmd;
				user_id <= next_cmd.uid;
				period <= next_cmd.per;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict accepted transactions, watchdog
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n) begin
			took = start && !busy;
			if (done) begin
				if (expected_grants.size() == 0) begin
					$error("unexpected result: sent_id %0h sent_time %0h status %0d",
						sent_id, sent_time, status);
					errors++;
				end else begin
					exp_g = expected_grants.pop_front();
					if (sent_id !== exp_g.id) begin
						$error("sent_id: expected %0h, got %0h", exp_g.id, sent_id);
						errors++;
					end
					if (sent_time !== exp_g.due) begin
						$error("sent_time: expected %0h, got %0h", exp_g.due, sent_time);
						errors++;
					end
					if (status !== exp_g.st) begin
						$error("status: expected %0d, got %0d", exp_g.st, status);
						errors++;
					end
				end
			end
			if (took)
				expected_grants.push_back(serve_command('{cmd, user_id, period}));
			if (took || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic push_cmd(logic [pdsch_pkg::CMD_W-1:0] c, logic [pdsch_pkg::ID_W-1:0] u,
			logic [pdsch_pkg::PER_W-1:0] p);
		pending_cmds.push_back('{c, u, p});
	endtask

	task automatic push_case(bit force_full);
		int mode;
		int n;
		int d;
		bit narrow;
		logic [pdsch_pkg::ID_W-1:0] u;
		logic [pdsch_pkg::PER_W-1:0] p;
		mode = $urandom_range(99);
		narrow = $urandom_range(99) < 60;
		if (!force_full && mode < 8) begin
			// noise
			repeat ($urandom_range(1, 6))
				push_cmd(pdsch_pkg::CMD_W'($urandom_range(3)), pdsch_pkg::ID_W'($urandom),
					pdsch_pkg::PER_W'($urandom));
			return;
		end
		if ($urandom_range(99) < 85)
			push_cmd(pdsch_pkg::CMD_CLR, pdsch_pkg::ID_W'($urandom),
				pdsch_pkg::PER_W'($urandom));
		n = (force_full || mode < 14) ? pdsch_pkg::CAPACITY + $urandom_range(3)
			: $urandom_range(1, 12);
		d = $urandom_range(n, 2 * n + 4);
		if (d > 40)
			d = 40;
		for (int i = 0; i < n + d; i++) begin
			if (i < n || $urandom_range(99) < 10) begin
				u = narrow ? pdsch_pkg::ID_W'($urandom_range(0, 5)) : pdsch_pkg::ID_W'($urandom);
				if ($urandom_range(99) < 4)
					p = '0;
				else if (narrow)
					p = pdsch_pkg::PER_W'($urandom_range(1, 4));
				else
					p = pdsch_pkg::PER_W'($urandom_range(1, 65535));
				push_cmd(pdsch_pkg::CMD_REG, u, p);
			end else begin
				push_cmd(pdsch_pkg::CMD_DISP, pdsch_pkg::ID_W'($urandom),
					pdsch_pkg::PER_W'($urandom));
			end
		end
		if ($urandom_range(99) < 10) begin
			push_cmd(pdsch_pkg::CMD_CLR, '0, '0);
			push_cmd(pdsch_pkg::CMD_DISP, '0, '0);
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || start || expected_grants.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_plan[4];
		idle_plan = '{0, 56, 0, 23};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_plan[ph];
			if (ph == 0) begin
				push_cmd(pdsch_pkg::CMD_DISP, '1, '1);
				push_cmd(CMD_NONE, '1, '1);
				push_cmd(pdsch_pkg::CMD_REG, 31'h7fffffff, 16'hffff);
				push_cmd(pdsch_pkg::CMD_REG, 31'h0, 16'h0001);
				push_cmd(pdsch_pkg::CMD_REG, 31'h5, 16'h0000);
				push_cmd(pdsch_pkg::CMD_REG, 31'h5, 16'h0000);
				push_cmd(pdsch_pkg::CMD_REG, 31'h3, 16'h0002);
				repeat (6) push_cmd(pdsch_pkg::CMD_DISP, '0, '0);
				push_cmd(pdsch_pkg::CMD_CLR, '1, '1);
				push_cmd(pdsch_pkg::CMD_DISP, '0, '0);
				push_cmd(pdsch_pkg::CMD_REG, 31'h2aaaaaaa, 16'h5555);
				push_cmd(pdsch_pkg::CMD_REG, 31'h55555555, 16'haaaa);
				push_cmd(pdsch_pkg::CMD_REG, 31'h2aaaaaaa, 16'h5555);
				repeat (4) push_cmd(pdsch_pkg::CMD_DISP, '0, '0);
				push_cmd(pdsch_pkg::CMD_CLR, '0, '0);
				push_case(1'b1);
			end
			while (pending_cmds.size() < PHASE_ITEMS)
				push_case(1'b0);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
